// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the frame decoder. Define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check a property at every rising edge while out of reset
`define ASSERT_CLK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// check a property at every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Types, constants and the byte-wide CRC16 update of the frame decoder.
// ----------------------------------------------------------------------------
package sld_pkg;

	localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
	localparam logic [7:0]  SYNC_SECOND = 8'h5A;
	localparam logic [15:0] CRC_START   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	// parser phase
	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_SYNC2   = 3'd1,
		PH_LENGTH  = 3'd2,
		PH_TYPE    = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_CRC_LO  = 3'd5,
		PH_CRC_HI  = 3'd6
	} phase_t;

	// kind of a result item
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_GOOD    = 2'd1,
		KIND_CRC_ERR = 2'd2
	} kind_t;

	// one result item
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  byte_index;
		logic [7:0]  frame_type;
		logic [7:0]  frame_length;
		logic [15:0] crc_computed;
		logic [15:0] crc_received;
		logic        last;
	} result_t;

	// CRC16-CCITT, MSB first, one byte
	function automatic logic [15:0] crc16_update(input logic [15:0] crc,
		input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: rtl/sld_in_if.sv
// ----------------------------------------------------------------------------
// sld_in_if
// Byte channel into the frame decoder: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface sld_in_if;

	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);

endinterface

// File: rtl/sld_out_if.sv
// ----------------------------------------------------------------------------
// sld_out_if
// Result channel out of the frame decoder: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface sld_out_if;

	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  byte_index;
	logic [7:0]  frame_type;
	logic [7:0]  frame_length;
	logic [15:0] crc_computed;
	logic [15:0] crc_received;
	logic        last;

	modport source (output valid, output kind, output payload_byte, output byte_index,
		output frame_type, output frame_length, output crc_computed,
		output crc_received, output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input byte_index,
		input frame_type, input frame_length, input crc_computed,
		input crc_received, input last, output ready);

endinterface

// File: rtl/sync_length_crc16_frame_decoder.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_decoder
// Parses A5 5A / length / type / payload / CRC16 frames from a byte stream.
// ----------------------------------------------------------------------------
// The decoder takes one byte per cycle while the sink keeps up, and hands out
// at most one result item per byte: each payload byte as it arrives, and one
// end item marked good or CRC error on the high CRC byte (CRC16-CCITT, seed
// FFFF, over sync, length, type and payload; received little-endian). A byte
// passes through an input register and the parser into a result register.
// Sustained rate is one byte per cycle, set by the combinational byte-wide
// CRC update in the parser; input ready drops only while both the input
// register and the result register are full and the sink stalls. On a CRC
// error end item the sink must discard that frame's payload bytes; the
// decoder itself does not enforce this.
module sync_length_crc16_frame_decoder (
	input  logic      clk,
	input  logic      arst_n,
	sld_in_if.sink    rx,
	sld_out_if.source result
);

	import sld_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       can_load;
	logic       emit;
	result_t    res;

	// step the parser whenever a byte is held and the result register can take its output
	assign advance  = valid_s1 && can_load;
	assign rx.ready = !valid_s1 || can_load;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	sld_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	sld_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && emit),
		.res      (res),
		.can_load (can_load),
		.tx       (result)
	);

`include "assert_macros.svh"

	`ASSERT_CLK(a_ready_when_empty, clk, arst_n, !valid_s1 |-> rx.ready)
	`ASSERT_CLK(a_stall_keeps_byte, clk, arst_n, (valid_s1 && !advance) |=> valid_s1)
	`ASSERT_CLK(a_end_not_payload, clk, arst_n,
		(result.valid && result.last) |-> (result.kind != KIND_PAYLOAD))
	`ASSERT_CLK(a_good_crc_match, clk, arst_n,
		(result.valid && result.kind == KIND_GOOD) |->
		(result.crc_computed == result.crc_received))
	`ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> (!valid_s1 && !result.valid))

endmodule

// File: rtl/sld_parser.sv
// ----------------------------------------------------------------------------
// sld_parser
// Frame parser and running CRC. Steps once per byte when advance is high and
// presents the result item that the byte causes, if any.
// ----------------------------------------------------------------------------
module sld_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       rx_byte,
	output logic             emit,
	output sld_pkg::result_t res
);

	import sld_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  crc_lo_q, crc_lo_d;

	logic [15:0] crc_upd;
	logic [15:0] crc_rcv;
	logic [8:0]  count_inc;

	// one shared byte update; a new frame starts from the seed
	assign crc_upd   = crc16_update((phase_q == PH_HUNT) ? CRC_START : crc_q, rx_byte);
	assign crc_rcv   = {rx_byte, crc_lo_q};
	assign count_inc = {1'b0, count_q} + 9'd1;

	// next state
	always_comb begin
		phase_d  = phase_q;
		crc_d    = crc_q;
		len_d    = len_q;
		type_d   = type_q;
		count_d  = count_q;
		crc_lo_d = crc_lo_q;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == SYNC_FIRST) begin
					crc_d   = crc_upd;
					phase_d = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					crc_d   = crc_upd;
					phase_d = PH_LENGTH;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_LENGTH: begin
				len_d   = rx_byte;
				crc_d   = crc_upd;
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				crc_d   = crc_upd;
				count_d = 8'd0;
				phase_d = (len_q == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_d   = crc_upd;
				count_d = count_inc[7:0];
				if (count_inc >= {1'b0, len_q}) begin
					phase_d = PH_CRC_LO;
				end
			end
			PH_CRC_LO: begin
				crc_lo_d = rx_byte;
				phase_d  = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// result item for the current byte
	always_comb begin
		emit             = 1'b0;
		res.kind         = KIND_PAYLOAD;
		res.payload_byte = 8'd0;
		res.byte_index   = 8'd0;
		res.frame_type   = type_q;
		res.frame_length = len_q;
		res.crc_computed = 16'd0;
		res.crc_received = 16'd0;
		res.last         = 1'b0;
		case (phase_q)
			PH_PAYLOAD: begin
				emit             = 1'b1;
				res.payload_byte = rx_byte;
				res.byte_index   = count_q;
			end
			PH_CRC_HI: begin
				emit             = 1'b1;
				res.kind         = (crc_rcv == crc_q) ? KIND_GOOD : KIND_CRC_ERR;
				res.crc_computed = crc_q;
				res.crc_received = crc_rcv;
				res.last         = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// parser state, stepped once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			crc_q    <= CRC_START;
			len_q    <= 8'd0;
			type_q   <= 8'd0;
			count_q  <= 8'd0;
			crc_lo_q <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_d;
			crc_q    <= crc_d;
			len_q    <= len_d;
			type_q   <= type_d;
			count_q  <= count_d;
			crc_lo_q <= crc_lo_d;
		end
	end

endmodule

// File: rtl/sld_out_reg.sv
// ----------------------------------------------------------------------------
// sld_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module sld_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sld_pkg::result_t res,
	output logic             can_load,
	sld_out_if.source        tx
);

	import sld_pkg::*;

	logic    valid_q;
	result_t data_q;

	// free when empty or when the held item transfers this cycle
	assign can_load = !valid_q || tx.ready;

	// hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// capture the payload
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			data_q <= res;
		end
	end

	assign tx.valid        = valid_q;
	assign tx.kind         = data_q.kind;
	assign tx.payload_byte = data_q.payload_byte;
	assign tx.byte_index   = data_q.byte_index;
	assign tx.frame_type   = data_q.frame_type;
	assign tx.frame_length = data_q.frame_length;
	assign tx.crc_computed = data_q.crc_computed;
	assign tx.crc_received = data_q.crc_received;
	assign tx.last         = data_q.last;

endmodule

// File: tb/sv/sync_length_crc16_frame_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_decoder_tb
// Drives byte streams into the frame decoder and checks every result item
// against a cycle-free predictor of the parser. A short table of directed
// bytes covers hunting, a bad second sync byte, zero length and good and bad
// CRC frames. Random frames, noise and cut-off frames follow. Both channels
// idle in random bursts, except in the closing stretch.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_decoder_tb;
	import sld_pkg::*;

	// how a table row gets its byte
	typedef enum logic [1:0] {
		FILL_AS_IS  = 2'd0,
		FILL_CRC_LO = 2'd1,
		FILL_CRC_HI = 2'd2
	} fill_t;

	typedef struct {
		logic [7:0] value;
		fill_t      fill;
		bit         typed;
		result_t    want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sld_in_if  rx_ch ();
	sld_out_if res_ch ();

	sync_length_crc16_frame_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.result (res_ch)
	);

	// parser state as predicted
	phase_t      parse_phase;
	logic [15:0] crc_run;
	logic [7:0]  frame_len;
	logic [7:0]  frame_type_q;
	logic [7:0]  pay_count;
	logic [7:0]  crc_lo_hold;

	result_t     pending_q[$];
	stim_row_t   dir_rows[$];
	int          mismatch_count;
	int          useful_count;
	int          big_frames;
	bit          quiet_tail;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// give up on a hung run
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// CRC16-CCITT, one input bit at a time, MSB first
	function automatic logic [15:0] ccitt_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = c[15] ^ b[i];
			c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
		end
		return c;
	endfunction

	function automatic result_t payload_item(input logic [7:0] b, input logic [7:0] idx,
		input logic [7:0] ftype, input logic [7:0] flen);
		result_t r;
		r = '0;
		r.kind         = KIND_PAYLOAD;
		r.payload_byte = b;
		r.byte_index   = idx;
		r.frame_type   = ftype;
		r.frame_length = flen;
		return r;
	endfunction

	function automatic string fmt_item(input result_t r);
		return $sformatf("kind=%0d byte=%h idx=%0d type=%h len=%0d crc_c=%h crc_r=%h last=%b",
			r.kind, r.payload_byte, r.byte_index, r.frame_type, r.frame_length,
			r.crc_computed, r.crc_received, r.last);
	endfunction

	// advance the predicted parser by one byte
	task automatic parse_byte(input logic [7:0] b, output bit produced, output result_t item);
		logic [15:0] rcv;
		produced = 1'b0;
		item = '0;
		case (parse_phase)
			PH_HUNT: begin
				if (b == SYNC_FIRST) begin
					crc_run = ccitt_next(CRC_START, b);
					parse_phase = PH_SYNC2;
				end
			end
			PH_SYNC2: begin
				// a wrong byte here drops back to the hunt, unchecked
				if (b == SYNC_SECOND) begin
					crc_run = ccitt_next(crc_run, b);
					parse_phase = PH_LENGTH;
				end else begin
					parse_phase = PH_HUNT;
				end
			end
			PH_LENGTH: begin
				frame_len = b;
				crc_run = ccitt_next(crc_run, b);
				parse_phase = PH_TYPE;
			end
			PH_TYPE: begin
				frame_type_q = b;
				crc_run = ccitt_next(crc_run, b);
				pay_count = 8'd0;
				parse_phase = (frame_len == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
			end
			PH_PAYLOAD: begin
				crc_run = ccitt_next(crc_run, b);
				item = payload_item(b, pay_count, frame_type_q, frame_len);
				produced = 1'b1;
				if ({1'b0, pay_count} + 9'd1 >= {1'b0, frame_len}) begin
					parse_phase = PH_CRC_LO;
				end
				pay_count = pay_count + 8'd1;
			end
			PH_CRC_LO: begin
				crc_lo_hold = b;
				parse_phase = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				rcv = {b, crc_lo_hold};
				item.kind         = (rcv == crc_run) ? KIND_GOOD : KIND_CRC_ERR;
				item.frame_type   = frame_type_q;
				item.frame_length = frame_len;
				item.crc_computed = crc_run;
				item.crc_received = rcv;
				item.last         = 1'b1;
				produced = 1'b1;
				parse_phase = PH_HUNT;
			end
			default: begin
				parse_phase = PH_HUNT;
			end
		endcase
	endtask

	// drive one byte and wait for its transfer; record what it should cause
	task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
		bit      produced;
		result_t item;
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			rx_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		rx_ch.valid   = 1'b1;
		rx_ch.rx_byte = b;
		do @(posedge clk); while (!rx_ch.ready);
		if (parse_phase != PH_HUNT || b == SYNC_FIRST) begin
			useful_count++;
		end
		parse_byte(b, produced, item);
		if (produced) begin
			pending_q.push_back(typed ? want : item);
		end
	endtask

	// hold the sender until every predicted result has arrived
	task automatic drain_results();
		@(negedge clk);
		rx_ch.valid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	// well-formed frame, CRC taken from the predictor and optionally spoiled
	task automatic send_frame(input int len, input bit corrupt);
		logic [7:0] flip_lo;
		logic [7:0] flip_hi;
		flip_lo = 8'h00;
		flip_hi = 8'h00;
		if (corrupt) begin
			do begin
				flip_lo = 8'($urandom_range(0, 255));
				flip_hi = 8'($urandom_range(0, 255));
			end while ({flip_hi, flip_lo} == 16'h0000);
		end
		send_byte(SYNC_FIRST, 1'b0, '0);
		send_byte(SYNC_SECOND, 1'b0, '0);
		send_byte(len[7:0], 1'b0, '0);
		send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		for (int i = 0; i < len; i++) begin
			send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end
		send_byte(crc_run[7:0] ^ flip_lo, 1'b0, '0);
		send_byte(crc_run[15:8] ^ flip_hi, 1'b0, '0);
	endtask

	// line noise; a stray first sync byte is followed by a wrong second one
	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 6)) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b, 1'b0, '0);
			if (b == SYNC_FIRST) begin
				b = 8'($urandom_range(0, 255));
				send_byte((b == SYNC_SECOND) ? SYNC_FIRST : b, 1'b0, '0);
			end
		end
	endtask

	task automatic add_row(input logic [7:0] value, input fill_t fill, input bit typed,
		input result_t want);
		stim_row_t r;
		r.value = value;
		r.fill  = fill;
		r.typed = typed;
		r.want  = want;
		dir_rows.push_back(r);
	endtask

	// result sink with random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				res_ch.ready = 1'b0;
				stall_left--;
			end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				res_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 4) - 1;
			end else begin
				res_ch.ready = 1'b1;
			end
		end
	end

	// compare each transfer on the result channel with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t got;
		result_t exp_item;
		bit      bad;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.kind         = kind_t'(res_ch.kind);
			got.payload_byte = res_ch.payload_byte;
			got.byte_index   = res_ch.byte_index;
			got.frame_type   = res_ch.frame_type;
			got.frame_length = res_ch.frame_length;
			got.crc_computed = res_ch.crc_computed;
			got.crc_received = res_ch.crc_received;
			got.last         = res_ch.last;
			if (pending_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("unexpected result: %s", fmt_item(got));
				end
			end else begin
				exp_item = pending_q.pop_front();
				bad = (got.kind !== exp_item.kind)
					|| (got.payload_byte !== exp_item.payload_byte)
					|| (got.byte_index !== exp_item.byte_index)
					|| (got.frame_type !== exp_item.frame_type)
					|| (got.frame_length !== exp_item.frame_length)
					|| (got.crc_computed !== exp_item.crc_computed)
					|| (got.crc_received !== exp_item.crc_received)
					|| (got.last !== exp_item.last);
				if (bad) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("mismatch at %0t", $realtime);
						$display("  expected %s", fmt_item(exp_item));
						$display("  actual   %s", fmt_item(got));
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [7:0] b;
		int         len;
		int         pick;
		bit         drained_mid;
		drained_mid   = 1'b0;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'h00;
		parse_phase   = PH_HUNT;
		crc_run       = CRC_START;
		frame_len     = 8'h00;
		frame_type_q  = 8'h00;
		pay_count     = 8'h00;
		crc_lo_hold   = 8'h00;

		// garbage while hunting
		add_row(8'h00, FILL_AS_IS, 1'b0, '0);
		add_row(8'hFF, FILL_AS_IS, 1'b0, '0);
		// wrong second sync byte: the second A5 is not taken as a new start
		add_row(SYNC_FIRST, FILL_AS_IS, 1'b0, '0);
		add_row(SYNC_FIRST, FILL_AS_IS, 1'b0, '0);
		add_row(SYNC_SECOND, FILL_AS_IS, 1'b0, '0);
		// zero length, CRC received as zero
		add_row(SYNC_FIRST, FILL_AS_IS, 1'b0, '0);
		add_row(SYNC_SECOND, FILL_AS_IS, 1'b0, '0);
		add_row(8'h00, FILL_AS_IS, 1'b0, '0);
		add_row(8'hFF, FILL_AS_IS, 1'b0, '0);
		add_row(8'h00, FILL_AS_IS, 1'b0, '0);
		add_row(8'h00, FILL_AS_IS, 1'b0, '0);
		// one payload byte, good CRC
		add_row(SYNC_FIRST, FILL_AS_IS, 1'b0, '0);
		add_row(SYNC_SECOND, FILL_AS_IS, 1'b0, '0);
		add_row(8'h01, FILL_AS_IS, 1'b0, '0);
		add_row(8'h00, FILL_AS_IS, 1'b0, '0);
		add_row(8'hFF, FILL_AS_IS, 1'b1, payload_item(8'hFF, 8'd0, 8'h00, 8'h01));
		add_row(8'h00, FILL_CRC_LO, 1'b0, '0);
		add_row(8'h00, FILL_CRC_HI, 1'b0, '0);
		// two payload bytes, good CRC
		add_row(SYNC_FIRST, FILL_AS_IS, 1'b0, '0);
		add_row(SYNC_SECOND, FILL_AS_IS, 1'b0, '0);
		add_row(8'h02, FILL_AS_IS, 1'b0, '0);
		add_row(8'h80, FILL_AS_IS, 1'b0, '0);
		add_row(8'h00, FILL_AS_IS, 1'b1, payload_item(8'h00, 8'd0, 8'h80, 8'h02));
		add_row(8'h7F, FILL_AS_IS, 1'b1, payload_item(8'h7F, 8'd1, 8'h80, 8'h02));
		add_row(8'h00, FILL_CRC_LO, 1'b0, '0);
		add_row(8'h00, FILL_CRC_HI, 1'b0, '0);

		// reset
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			case (dir_rows[i].fill)
				FILL_CRC_LO: b = crc_run[7:0];
				FILL_CRC_HI: b = crc_run[15:8];
				default:     b = dir_rows[i].value;
			endcase
			send_byte(b, dir_rows[i].typed, dir_rows[i].want);
		end
		drain_results();

		// random frames, noise and cut-off frames
		while (useful_count < 770) begin
			quiet_tail = (useful_count >= 690);
			if (!drained_mid && useful_count >= 400) begin
				drain_results();
				drained_mid = 1'b1;
				// one frame of the largest length
				send_frame(255, 1'($urandom_range(0, 1)));
				big_frames++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				len = $urandom_range(0, 39);
				if (len == 0 && big_frames < 2) begin
					len = 255;
					big_frames++;
				end else if (len < 5) begin
					len = 0;
				end else begin
					len = $urandom_range(1, 8);
				end
				send_frame(len, $urandom_range(0, 3) == 0);
			end else if (pick < 88) begin
				send_noise();
			end else begin
				// frame cut short; the next bytes are parsed as its rest
				len = $urandom_range(2, 10);
				send_byte(SYNC_FIRST, 1'b0, '0);
				send_byte(SYNC_SECOND, 1'b0, '0);
				send_byte(len[7:0], 1'b0, '0);
				send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
				repeat ($urandom_range(0, len - 1)) begin
					send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
				end
			end
		end

		// wind down
		drain_results();
		repeat (10) @(posedge clk);
		if (pending_q.size() != 0) begin
			mismatch_count++;
			$display("%0d results never arrived", pending_q.size());
		end
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
